[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an asynchronous, active-low reset as disable.
`define RRRS_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same, on the usual clock and reset port names.
`define RRRS_ASSERT(lbl, prop, msg) \
  `RRRS_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

[rtl/core/rrrs_pkg.sv]
// Types and constants of the recent record ring search block.
package rrrs_pkg;

  localparam int unsigned ACT_W  = 2;
  localparam int unsigned ADDR_W = 48;
  localparam int unsigned MIN_W  = 32;
  localparam int unsigned IDX_W  = 31;

  localparam logic [IDX_W-1:0] COUNT_MAX = {IDX_W{1'b1}};

  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND    = 2'd0,
    ACT_FIND_ADDR = 2'd1,
    ACT_FIND_MIN  = 2'd2
  } action_e;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [MIN_W-1:0]  minute;
  } rec_t;

  // Per-cycle command to every cell of the chain.
  typedef struct packed {
    logic append;  // take the newer neighbour, cell 0 takes the new record
    logic rotate;  // take the older neighbour, the last cell takes cell 0
  } cell_ctl_t;

endpackage

[rtl/core/rrrs_cell.sv]
// One record cell of the ring chain.
module rrrs_cell (
  input  logic               clk_i,
  input  rrrs_pkg::cell_ctl_t ctl_i,
  input  rrrs_pkg::rec_t     prev_i,
  input  rrrs_pkg::rec_t     next_i,
  output rrrs_pkg::rec_t     rec_o
);
  import rrrs_pkg::*;

  rec_t rec_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.append) begin
      rec_q <= prev_i;
    end else if (ctl_i.rotate) begin
      rec_q <= next_i;
    end
  end

  assign rec_o = rec_q;

endmodule

[rtl/core/recent_record_ring_search.sv]
// Top level: ring of recent records held in a chain of cells, with backward search.
//
// Input channel (in_valid_i / in_stall_o) carries one beat per action: append a
// record, find an address since a minute, or find the first index of a minute.
// Output channel (out_valid_o / out_stall_i) gives exactly one beat per input
// beat: found_o and record_index_o.
// Records sit in a chain of RING_DEPTH cells, newest in cell 0. An append
// shifts the chain by one; the result is in the output register in the cycle after
// the input beat, and the next beat can follow at once unless that result stalls.
// Once the append count saturates, an append overwrites the oldest cell in place.
// A search rotates the whole chain once around, checking the record passing
// cell 0; the chain is back in place when it ends. A search beat goes through
// the walk state and then the emit state, which waits for a free output
// register, before its result is registered; no new beat is taken meanwhile.
// An unused action code answers not found and changes nothing.
// Reset clears the append count and the control; record contents stay
// undefined until written and are never read before that.
// A stalled result holds in the output register; new input is held off while
// that register is full and stalled, and while a search is under way.
module recent_record_ring_search #(
  parameter int unsigned RING_DEPTH = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [rrrs_pkg::ACT_W-1:0]  action_i,
  input  logic [rrrs_pkg::ADDR_W-1:0] mac_address_i,
  input  logic [rrrs_pkg::MIN_W-1:0]  minute_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        found_o,
  output logic [rrrs_pkg::IDX_W-1:0]  record_index_o
);
  import rrrs_pkg::*;

  localparam int unsigned CNT_W = (RING_DEPTH > 2) ? $clog2(RING_DEPTH) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RING_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_CAP  = CNT_W'(RING_DEPTH - 2);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [IDX_W-1:0]  count_q, count_d;
  logic              live_q, live_d;
  logic              done_q, done_d;
  logic              out_valid_q, out_valid_d;

  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              res_found_q, res_found_d;
  logic [IDX_W-1:0]  res_idx_q, res_idx_d;
  logic              out_found_q, out_found_d;
  logic [IDX_W-1:0]  out_idx_q, out_idx_d;
  logic              find_min_q;
  logic [ADDR_W-1:0] tgt_addr_q;
  logic [MIN_W-1:0]  tgt_min_q;

  logic      accept;
  logic      out_free;
  logic      sat_append;
  action_e   act;
  cell_ctl_t ctl;
  rec_t      new_rec;
  rec_t      cell_rec [RING_DEPTH];
  rec_t      head;

  assign act      = action_e'(action_i);
  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign head     = cell_rec[0];

  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);

  assign new_rec.addr   = mac_address_i;
  assign new_rec.minute = minute_i;

  assign ctl.append = accept && (act == ACT_APPEND) && (count_q != COUNT_MAX);
  assign ctl.rotate = (state_q == ST_WALK);
  // saturated count: the new record replaces the oldest one, no shift
  assign sat_append = accept && (act == ACT_APPEND) && (count_q == COUNT_MAX);

  for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
    logic      last_load;
    cell_ctl_t cell_ctl;
    assign last_load = (i == RING_DEPTH - 1) && sat_append;
    assign cell_ctl  = last_load ? cell_ctl_t'{append: 1'b1, rotate: 1'b0} : ctl;
    rrrs_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  (cell_ctl),
      .prev_i ((i == 0 || last_load) ? new_rec
                                     : cell_rec[(i + RING_DEPTH - 1) % RING_DEPTH]),
      .next_i (cell_rec[(i + 1) % RING_DEPTH]),
      .rec_o  (cell_rec[i])
    );
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    count_d     = count_q;
    live_d      = live_q;
    done_d      = done_q;
    out_valid_d = out_valid_q;
    idx_d       = idx_q;
    res_found_d = res_found_q;
    res_idx_d   = res_idx_q;
    out_found_d = out_found_q;
    out_idx_d   = out_idx_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (act)
            ACT_APPEND: begin
              out_valid_d = 1'b1;
              out_found_d = 1'b1;
              out_idx_d   = count_q;
              if (count_q != COUNT_MAX) begin
                count_d = count_q + IDX_W'(1);
              end
            end
            ACT_FIND_ADDR, ACT_FIND_MIN: begin
              state_d     = ST_WALK;
              cnt_d       = '0;
              idx_d       = count_q - IDX_W'(1);
              live_d      = (count_q != '0);
              done_d      = 1'b0;
              res_found_d = 1'b0;
              res_idx_d   = '0;
            end
            default: begin
              out_valid_d = 1'b1;
              out_found_d = 1'b0;
              out_idx_d   = '0;
            end
          endcase
        end
      end
      ST_WALK: begin
        // cell 0 holds the record with running index idx_q
        if (!done_q && live_q) begin
          if (find_min_q) begin
            if (head.minute < tgt_min_q) begin
              done_d      = 1'b1;
              res_found_d = 1'b1;
              res_idx_d   = idx_q + IDX_W'(1);
            end else if (idx_q == '0) begin
              done_d      = 1'b1;
              res_found_d = 1'b1;
              res_idx_d   = '0;
            end else if (cnt_q == CNT_CAP) begin
              // walk limit: oldest record still held, not examined
              done_d      = 1'b1;
              res_found_d = 1'b1;
              res_idx_d   = idx_q - IDX_W'(1);
            end
          end else begin
            if (head.minute < tgt_min_q) begin
              done_d = 1'b1;
            end else if (head.addr == tgt_addr_q) begin
              done_d      = 1'b1;
              res_found_d = 1'b1;
              res_idx_d   = idx_q;
            end
          end
        end
        if (idx_q == '0) begin
          live_d = 1'b0;
        end
        idx_d = idx_q - IDX_W'(1);
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_found_d = res_found_q;
          out_idx_d   = res_idx_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      count_q     <= '0;
      live_q      <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      count_q     <= count_d;
      live_q      <= live_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    res_found_q <= res_found_d;
    res_idx_q   <= res_idx_d;
    out_found_q <= out_found_d;
    out_idx_q   <= out_idx_d;
    if (accept) begin
      find_min_q <= (act == ACT_FIND_MIN);
      tgt_addr_q <= mac_address_i;
      tgt_min_q  <= minute_i;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = out_found_q;
  assign record_index_o = out_idx_q;

endmodule

[rtl/core/rrrs_checker.sv]
// Port-level checker for the recent record ring search block, with its bind.
`include "assert_macros.svh"

module rrrs_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic [rrrs_pkg::ACT_W-1:0]  action_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic                        found_o,
  input logic [rrrs_pkg::IDX_W-1:0]  record_index_o
);
  import rrrs_pkg::*;

  logic in_beat;
  assign in_beat = in_valid_i && !in_stall_o;

  `RRRS_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(found_o) && $stable(record_index_o), "stalled result beat changed")
  `RRRS_ASSERT(a_miss_zero, out_valid_o && !found_o |-> record_index_o == '0, "not-found beat with non-zero index")
  `RRRS_ASSERT(a_append_result, in_beat && action_i == ACT_APPEND |=> out_valid_o && found_o, "append gave no found result next cycle")
  `RRRS_ASSERT(a_search_busy, in_beat && (action_i == ACT_FIND_ADDR || action_i == ACT_FIND_MIN) |=> in_stall_o, "input taken during a search walk")

endmodule

bind recent_record_ring_search rrrs_checker u_rrrs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .action_i       (action_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .found_o        (found_o),
  .record_index_o (record_index_o)
);
